>>> src/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse unit.
`timescale 1ns / 1ps
`default_nettype none

package m3i_pkg;

  // Element width of the Q-format input and output matrices
  localparam int unsigned ELEM_W = 32;
  // Product of two elements
  localparam int unsigned PROD_W = 2 * ELEM_W;
  // Adjugate entry: difference of two products
  localparam int unsigned ADJ_W  = 2 * ELEM_W + 1;
  // Determinant: sum of three element-by-adjugate products, with headroom
  localparam int unsigned DET_W  = 3 * ELEM_W + 3;
  // Quotient bits kept by the divider: one beyond the element range
  localparam int unsigned QUO_W  = ELEM_W + 1;
  // One divider lane per matrix element
  localparam int unsigned LANES  = 9;

  // Saturation limits on the quotient magnitude
  localparam logic [QUO_W-1:0] SAT_POS = {2'b00, {(ELEM_W - 1){1'b1}}};
  localparam logic [QUO_W-1:0] SAT_NEG = {2'b01, {(ELEM_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } mat_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] b00;
    logic signed [ELEM_W-1:0] b01;
    logic signed [ELEM_W-1:0] b02;
    logic signed [ELEM_W-1:0] b10;
    logic signed [ELEM_W-1:0] b11;
    logic signed [ELEM_W-1:0] b12;
    logic signed [ELEM_W-1:0] b20;
    logic signed [ELEM_W-1:0] b21;
    logic signed [ELEM_W-1:0] b22;
    logic                     singular;
    logic                     overflow;
  } mat_out_t;

  // Per-element state carried down the divider chain
  typedef struct packed {
    logic             neg;   // result sign
    logic             big;   // quotient exceeds the kept bits: saturate
    logic [DET_W-1:0] rem;   // partial remainder
    logic [QUO_W-1:0] low;   // numerator bits still to be shifted in
    logic [QUO_W-1:0] quo;   // quotient bits so far
  } lane_t;

  // Per-item control shared by all lanes of one divider cell
  typedef struct packed {
    logic             valid;
    logic             singular;
    logic [DET_W-1:0] dmag;  // determinant magnitude
  } div_ctl_t;

endpackage

`default_nettype wire

>>> src/matrix3x3_inverse_unit.sv
// Top level: 3x3 signed fixed-point matrix inverse by adjugate.
// Pipeline: 7 front-end stages (products, adjugate, determinant and set-up), 33
// divider cells and 1 output register between input transfer and output valid.
// Throughput: one matrix per cycle while the skid register is empty. A skid register
// behind the output keeps in_stall_o a plain flop; while occupied it stalls the pipeline.
// Reset clears all valid bits, including the output and skid valids; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module matrix3x3_inverse_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire m3i_pkg::mat_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output m3i_pkg::mat_out_t      out_data_o
);

  localparam int unsigned EW    = m3i_pkg::ELEM_W;
  localparam int unsigned QW    = m3i_pkg::QUO_W;
  localparam int unsigned NL    = m3i_pkg::LANES;
  localparam int unsigned CELLS = m3i_pkg::QUO_W;

  logic                    en;
  m3i_pkg::div_ctl_t       ctl   [CELLS+1];
  m3i_pkg::lane_t [NL-1:0] lanes [CELLS+1];
  logic signed [EW-1:0]    res   [NL];
  logic [NL-1:0]           sat;
  logic [EW-1:0]           mag   [NL];
  m3i_pkg::mat_out_t       pipe_data;
  logic                    pipe_valid;
  logic                    out_valid_d, out_valid_q;
  logic                    skid_valid_d, skid_valid_q;
  m3i_pkg::mat_out_t       out_d, out_q;
  m3i_pkg::mat_out_t       skid_d, skid_q;

  // Hold the whole pipeline while the skid register is occupied
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  m3i_adj_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (in_data_i),
    .ctl_o   (ctl[0]),
    .lanes_o (lanes[0])
  );

  // Chain of divider cells, one quotient bit each
  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    m3i_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (ctl[c]),
      .lanes_i (lanes[c]),
      .ctl_o   (ctl[c+1]),
      .lanes_o (lanes[c+1])
    );
  end

  // Saturate, apply the sign, zero the result of a singular matrix
  always_comb begin
    for (int e = 0; e < NL; e++) begin
      sat[e] = lanes[CELLS][e].big
            || (!lanes[CELLS][e].neg && (lanes[CELLS][e].quo > m3i_pkg::SAT_POS))
            || ( lanes[CELLS][e].neg && (lanes[CELLS][e].quo > m3i_pkg::SAT_NEG));
      mag[e] = lanes[CELLS][e].quo[EW-1:0];
      if (ctl[CELLS].singular) begin
        res[e] = '0;
      end else if (sat[e]) begin
        res[e] = lanes[CELLS][e].neg ? {1'b1, {(EW - 1){1'b0}}}
                                     : {1'b0, {(EW - 1){1'b1}}};
      end else begin
        res[e] = lanes[CELLS][e].neg ? EW'(-mag[e]) : EW'(mag[e]);
      end
    end
    pipe_data.b00      = res[0];
    pipe_data.b01      = res[1];
    pipe_data.b02      = res[2];
    pipe_data.b10      = res[3];
    pipe_data.b11      = res[4];
    pipe_data.b12      = res[5];
    pipe_data.b20      = res[6];
    pipe_data.b21      = res[7];
    pipe_data.b22      = res[8];
    pipe_data.singular = ctl[CELLS].singular;
    pipe_data.overflow = (|sat) && !ctl[CELLS].singular;
  end

  assign pipe_valid = ctl[CELLS].valid;
  // QW is the quotient width carried by each cell; keep the chain length tied to it
  localparam int unsigned CHAIN_CHECK = QW - CELLS;

  // Output register with skid: drain the skid first, park a transfer in it
  // when the output is stalled
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && out_stall_i) begin
      if (pipe_valid) begin
        skid_d       = pipe_data;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = pipe_valid;
      out_d       = pipe_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register occupied without a pending output");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i && pipe_valid))
    else $error("skid register filled without a stalled output");

  a_singular_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.singular) |->
      (!out_data_o.overflow && (out_data_o.b00 == '0) && (out_data_o.b11 == '0)
       && (out_data_o.b22 == '0)))
    else $error("singular result carries nonzero data or overflow");

  a_chain_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CHAIN_CHECK == 0) || !out_valid_o)
    else $error("divider chain length does not match quotient width");

endmodule

`default_nettype wire

>>> src/m3i_div_cell.sv
// One restoring-division step for all nine elements of one matrix.
`timescale 1ns / 1ps
`default_nettype none

module m3i_div_cell (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire m3i_pkg::div_ctl_t                      ctl_i,
  input  wire m3i_pkg::lane_t [m3i_pkg::LANES-1:0]    lanes_i,
  output m3i_pkg::div_ctl_t                           ctl_o,
  output m3i_pkg::lane_t [m3i_pkg::LANES-1:0]         lanes_o
);

  localparam int unsigned DW = m3i_pkg::DET_W;
  localparam int unsigned QW = m3i_pkg::QUO_W;
  localparam int unsigned NL = m3i_pkg::LANES;

  logic                               valid_q;
  m3i_pkg::div_ctl_t                  ctl_q;
  m3i_pkg::lane_t [NL-1:0]            lanes_d;
  m3i_pkg::lane_t [NL-1:0]            lanes_q;
  logic [DW:0]                        trial [NL];
  logic [DW:0]                        diff  [NL];
  logic                               ge    [NL];

  // Shift in the next numerator bit, subtract the divisor where it fits
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      trial[l] = {lanes_i[l].rem, lanes_i[l].low[QW-1]};
      diff[l]  = trial[l] - {1'b0, ctl_i.dmag};
      ge[l]    = (trial[l] >= {1'b0, ctl_i.dmag});
      lanes_d[l].neg = lanes_i[l].neg;
      lanes_d[l].big = lanes_i[l].big;
      lanes_d[l].rem = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
      lanes_d[l].low = {lanes_i[l].low[QW-2:0], 1'b0};
      lanes_d[l].quo = {lanes_i[l].quo[QW-2:0], ge[l]};
    end
  end

  // Advance the item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q   <= ctl_i;
      lanes_q <= lanes_d;
    end
  end

  always_comb begin
    ctl_o       = ctl_q;
    ctl_o.valid = valid_q;
  end

  assign lanes_o = lanes_q;

endmodule

`default_nettype wire

>>> src/m3i_adj_det.sv
// Front end: adjugate, determinant and divider set-up in seven stages.
`timescale 1ns / 1ps
`default_nettype none

module m3i_adj_det #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic                                   valid_i,
  input  wire m3i_pkg::mat_in_t                       mat_i,
  output m3i_pkg::div_ctl_t                           ctl_o,
  output m3i_pkg::lane_t [m3i_pkg::LANES-1:0]         lanes_o
);

  localparam int unsigned EW    = m3i_pkg::ELEM_W;
  localparam int unsigned PW    = m3i_pkg::PROD_W;
  localparam int unsigned AW    = m3i_pkg::ADJ_W;
  localparam int unsigned DW    = m3i_pkg::DET_W;
  localparam int unsigned QW    = m3i_pkg::QUO_W;
  localparam int unsigned NL    = m3i_pkg::LANES;
  localparam int unsigned NUM_W = AW + 2 * FRAC_BITS;
  localparam int unsigned HI_W  = NUM_W - QW;
  localparam int unsigned PP_W  = 2 * EW + 1;

  logic signed [EW-1:0]    a [3][3];
  logic [6:0]              valid_q;

  // Stage 1 products, stage 2 adjugate
  logic signed [PW-1:0]    p0_d [NL];
  logic signed [PW-1:0]    p1_d [NL];
  logic signed [PW-1:0]    p0_q [NL];
  logic signed [PW-1:0]    p1_q [NL];
  logic signed [EW-1:0]    c0_1_q [3];
  logic signed [AW-1:0]    adj2_q [NL];
  logic signed [EW-1:0]    c0_2_q [3];
  // Stage 3 partial products, stage 4 terms, stage 5 determinant
  logic signed [AW-1:0]    adj3_q [NL];
  logic signed [PP_W-1:0]  lo_q [3];
  logic signed [PP_W-1:0]  hi_q [3];
  logic signed [AW-1:0]    adj4_q [NL];
  logic signed [DW-1:0]    term_q [3];
  logic signed [AW-1:0]    adj5_q [NL];
  logic signed [DW-1:0]    det_q;
  // Stage 6 magnitudes and signs
  logic [AW-1:0]           amag_q [NL];
  logic                    neg6_q [NL];
  logic [DW-1:0]           dmag_q;
  logic                    sing_q;
  // Stage 7 divider set-up
  logic [NUM_W-1:0]        num   [NL];
  logic [HI_W-1:0]         num_hi[NL];
  m3i_pkg::lane_t [NL-1:0] lanes_d;
  m3i_pkg::lane_t [NL-1:0] lanes_q;
  logic [DW-1:0]           dmag7_q;
  logic                    sing7_q;

  assign a[0][0] = mat_i.a00;
  assign a[0][1] = mat_i.a01;
  assign a[0][2] = mat_i.a02;
  assign a[1][0] = mat_i.a10;
  assign a[1][1] = mat_i.a11;
  assign a[1][2] = mat_i.a12;
  assign a[2][0] = mat_i.a20;
  assign a[2][1] = mat_i.a21;
  assign a[2][2] = mat_i.a22;

  // Form the two products of each adjugate entry: row r is the cross
  // product of columns r+1 and r+2
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      assign p0_d[r*3+k] = a[(k+1)%3][(r+1)%3] * a[(k+2)%3][(r+2)%3];
      assign p1_d[r*3+k] = a[(k+2)%3][(r+1)%3] * a[(k+1)%3][(r+2)%3];
    end
  end

  // Advance the item valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[5:0], valid_i};
    end
  end

  // Arithmetic stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int e = 0; e < NL; e++) begin
        p0_q[e]   <= p0_d[e];
        p1_q[e]   <= p1_d[e];
        adj2_q[e] <= AW'(p0_q[e]) - AW'(p1_q[e]);
        adj3_q[e] <= adj2_q[e];
        adj4_q[e] <= adj3_q[e];
        adj5_q[e] <= adj4_q[e];
        amag_q[e] <= adj5_q[e][AW-1] ? AW'(-adj5_q[e]) : AW'(adj5_q[e]);
        neg6_q[e] <= adj5_q[e][AW-1] ^ det_q[DW-1];
      end
      for (int k = 0; k < 3; k++) begin
        c0_1_q[k] <= a[k][0];
        c0_2_q[k] <= c0_1_q[k];
        lo_q[k]   <= $signed({1'b0, adj2_q[k][EW-1:0]}) * c0_2_q[k];
        hi_q[k]   <= $signed(adj2_q[k][AW-1:EW]) * c0_2_q[k];
        term_q[k] <= (DW'(hi_q[k]) <<< EW) + DW'(lo_q[k]);
      end
      det_q   <= term_q[0] + term_q[1] + term_q[2];
      dmag_q  <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      sing_q  <= (det_q == '0);
      lanes_q <= lanes_d;
      dmag7_q <= dmag_q;
      sing7_q <= sing_q;
    end
  end

  // Scale the numerator and load the first partial remainder; flag
  // quotients too large for the kept bits
  always_comb begin
    for (int e = 0; e < NL; e++) begin
      num[e]         = {amag_q[e], {(2 * FRAC_BITS){1'b0}}};
      num_hi[e]      = num[e][NUM_W-1:QW];
      lanes_d[e].neg = neg6_q[e];
      lanes_d[e].big = (DW'(num_hi[e]) >= dmag_q);
      lanes_d[e].rem = DW'(num_hi[e]);
      lanes_d[e].low = num[e][QW-1:0];
      lanes_d[e].quo = '0;
    end
  end

  assign ctl_o   = '{valid: valid_q[6], singular: sing7_q, dmag: dmag7_q};
  assign lanes_o = lanes_q;

endmodule

`default_nettype wire

>>> tb/sv/matrix3x3_inverse_unit_tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit.
`timescale 1ns / 1ps

module matrix3x3_inverse_unit_tb;

  localparam int unsigned FRAC   = 16;
  localparam int unsigned WIDE   = 192;
  localparam int unsigned LATENCY = 41;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_AT = 600;
  localparam int unsigned QUIET_FROM = 200;
  localparam int unsigned QUIET_TO = 500;
  localparam logic signed [m3i_pkg::ELEM_W-1:0] ONE = 32'sh0001_0000;

  typedef logic signed [WIDE-1:0] wide_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  m3i_pkg::mat_in_t   in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  m3i_pkg::mat_out_t  out_data_o;

  m3i_pkg::mat_in_t   pending_q[$];
  m3i_pkg::mat_out_t  inverse_q[$];
  int        sent_count = 0;
  int        checked_count = 0;
  int        singular_count = 0;
  int        overflow_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        quiet_cycles = 0;
  logic      in_fired = 1'b0;
  logic      stim_done = 1'b0;

  matrix3x3_inverse_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  // Expected inverse of one matrix: exact adjugate and determinant, truncating divide
  function automatic m3i_pkg::mat_out_t inverse_of(m3i_pkg::mat_in_t m);
    wide_t e[9];
    wide_t adj[9];
    wide_t det, dmag, num, q, res;
    logic neg, ovf;
    logic [m3i_pkg::ELEM_W-1:0] b[9];
    m3i_pkg::mat_out_t o;
    e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
    e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
    e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
    // element k of column c is e[k*3+c]; adjugate row r is a cross product
    for (int r = 0; r < 3; r++) begin
      int u, v;
      u = (r + 1) % 3;
      v = (r + 2) % 3;
      for (int k = 0; k < 3; k++) begin
        int k1, k2;
        k1 = (k + 1) % 3;
        k2 = (k + 2) % 3;
        adj[r*3+k] = e[k1*3+u] * e[k2*3+v] - e[k2*3+u] * e[k1*3+v];
      end
    end
    det = 0;
    for (int k = 0; k < 3; k++) det = det + e[k*3] * adj[k];
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    dmag = det < 0 ? -det : det;
    ovf = 1'b0;
    for (int i = 0; i < 9; i++) begin
      num = adj[i] <<< (2 * FRAC);
      neg = (num < 0) != (det < 0);
      q = $unsigned(num < 0 ? -num : num) / $unsigned(dmag);
      if (!neg && $unsigned(q) > 192'h7FFF_FFFF) begin
        q = 192'h7FFF_FFFF;
        ovf = 1'b1;
      end
      if (neg && $unsigned(q) > 192'h8000_0000) begin
        q = 192'h8000_0000;
        ovf = 1'b1;
      end
      res = neg ? -q : q;
      b[i] = res[m3i_pkg::ELEM_W-1:0];
    end
    o.b00 = b[0]; o.b01 = b[1]; o.b02 = b[2];
    o.b10 = b[3]; o.b11 = b[4]; o.b12 = b[5];
    o.b20 = b[6]; o.b21 = b[7]; o.b22 = b[8];
    o.overflow = ovf;
    return o;
  endfunction

  function automatic m3i_pkg::mat_in_t mat_of(logic signed [m3i_pkg::ELEM_W-1:0] x0, x1,
                                              x2, x3, x4, x5, x6, x7, x8);
    m3i_pkg::mat_in_t m;
    m.a00 = x0; m.a01 = x1; m.a02 = x2;
    m.a10 = x3; m.a11 = x4; m.a12 = x5;
    m.a20 = x6; m.a21 = x7; m.a22 = x8;
    return m;
  endfunction

  // Random element in +/- span (two's complement around zero)
  function automatic logic signed [m3i_pkg::ELEM_W-1:0] near_zero(int unsigned span);
    return $signed($urandom_range(2 * span, 0)) - $signed(span);
  endfunction

  function automatic m3i_pkg::mat_in_t random_matrix();
    m3i_pkg::mat_in_t m;
    int unsigned kind;
    kind = $urandom_range(99, 0);
    m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    if (kind < 45) begin
      // well-conditioned: moderate elements, a strong diagonal on part of them
      m = mat_of(near_zero(32'h4_0000), near_zero(32'h4_0000), near_zero(32'h4_0000),
                 near_zero(32'h4_0000), near_zero(32'h4_0000), near_zero(32'h4_0000),
                 near_zero(32'h4_0000), near_zero(32'h4_0000), near_zero(32'h4_0000));
      if (kind < 25) begin
        m.a00 = m.a00 + 32'sh8_0000;
        m.a11 = m.a11 - 32'sh8_0000;
        m.a22 = m.a22 + 32'sh8_0000;
      end
    end else if (kind < 60) begin
      // small fractions: large inverse, saturation likely
      m = mat_of(near_zero(300), near_zero(300), near_zero(300),
                 near_zero(300), near_zero(300), near_zero(300),
                 near_zero(300), near_zero(300), near_zero(300));
    end else if (kind < 72) begin
      // rank deficient: third row a copy or sum of others
      m.a20 = m.a00 + m.a10;
      m.a21 = m.a01 + m.a11;
      m.a22 = m.a02 + m.a12;
      if (kind < 66) begin
        m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
      end
    end else if (kind < 80) begin
      // tiny integers, exact small determinants
      m = mat_of(near_zero(3), near_zero(3), near_zero(3), near_zero(3), near_zero(3),
                 near_zero(3), near_zero(3), near_zero(3), near_zero(3));
    end
    return m;
  endfunction

  // Fill the item queue: directed corners first, then random matrices
  initial begin
    pending_q.push_back(mat_of(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    pending_q.push_back(mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mat_of(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    pending_q.push_back(mat_of(2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, -8 * ONE));
    pending_q.push_back(mat_of(1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_q.push_back(mat_of(-1, 0, 0, 0, 1, 0, 0, 0, -1));
    pending_q.push_back(mat_of(32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0,
                               32'sh7FFF_FFFF));
    pending_q.push_back(mat_of(32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0,
                               32'sh8000_0000));
    pending_q.push_back(mat_of(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                               32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
    pending_q.push_back(mat_of(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    pending_q.push_back(mat_of(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_q.push_back(mat_of(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    pending_q.push_back(mat_of(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                               7 * ONE, 8 * ONE, 10 * ONE));
    pending_q.push_back(mat_of(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                               7 * ONE, 8 * ONE, 9 * ONE));
    pending_q.push_back(mat_of(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE));
    pending_q.push_back(mat_of(ONE, 0, 0, 0, ONE, 0, 0, 0, 32'sh0000_8000));
    pending_q.push_back(mat_of(32'sh7FFF_FFFF, 0, 0, 0, 1, 0, 0, 0, ONE));
    pending_q.push_back(mat_of(32'sh8000_0000, 0, 0, 0, -1, 0, 0, 0, -ONE));
    for (int i = 0; i < 1100; i++) pending_q.push_back(random_matrix());
  end

  // Hold reset low at start, then release it on a falling clock edge
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  // Predict on each input transfer and check each output transfer
  always @(posedge clk_i) begin
    m3i_pkg::mat_out_t want;
    int errs;
    errs = 0;
    cycle_count <= cycle_count + 1;
    in_fired <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      inverse_q.push_back(inverse_of(in_data_i));
      sent_count <= sent_count + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: output transfer expected none, actual %h", $time, out_data_o);
        errs = errs + 1;
      end else begin
        want = inverse_q.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (out_data_o[289-32*f -: 32] !== want[289-32*f -: 32]) begin
            $display("%0t: element b%0d%0d expected %h actual %h", $time, f / 3, f % 3,
                     want[289-32*f -: 32], out_data_o[289-32*f -: 32]);
            errs = errs + 1;
          end
        end
        if (out_data_o.singular !== want.singular) begin
          $display("%0t: singular expected %b actual %b", $time, want.singular,
                   out_data_o.singular);
          errs = errs + 1;
        end
        if (out_data_o.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                   out_data_o.overflow);
          errs = errs + 1;
        end
        if (want.singular) singular_count <= singular_count + 1;
        if (want.overflow) overflow_count <= overflow_count + 1;
        checked_count <= checked_count + 1;
      end
    end
    error_count <= error_count + errs;
  end

  // Drive the input side: hold a stalled item, otherwise idle or advance
  always @(negedge clk_i) begin
    logic quiet;
    quiet = cycle_count > QUIET_FROM && cycle_count < QUIET_TO;
    if (rst_ni && !(in_valid_i && !in_fired)) begin
      if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end else if (sent_count == DRAIN_AT && inverse_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(99, 0) < 9) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_q.pop_front();
      end
    end
  end

  // Drive the output stall
  always @(negedge clk_i) begin
    out_stall_i <= !(cycle_count > QUIET_FROM && cycle_count < QUIET_TO)
                   && $urandom_range(99, 0) < 9;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Wait for drain, then report
  initial begin
    wait (stim_done);
    wait (inverse_q.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
             sent_count, checked_count, singular_count, overflow_count);
    $display("Random stall on both sides, one full drain mid-run, %0d mismatches.",
             error_count);
    if (error_count == 0 && inverse_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
